### rtl/htw_pkg.sv
// Shared constants and codes of the hierarchical timer wheel.
package htw_pkg;

	localparam int ENTRIES    = 64;
	localparam int EW         = $clog2(ENTRIES);
	localparam int HEAD_W     = EW + 1;
	localparam int HANDLES    = 256;
	localparam int MS_SLOTS   = 1000;
	localparam int SEC_SLOTS  = 60;
	localparam int HOUR_SLOTS = 24;
	localparam int NSLOTS     = MS_SLOTS + 2 * SEC_SLOTS + HOUR_SLOTS;
	localparam int SLOT_W     = $clog2(NSLOTS);

	localparam logic [SLOT_W-1:0] SEC_BASE  = SLOT_W'(MS_SLOTS);
	localparam logic [SLOT_W-1:0] MIN_BASE  = SLOT_W'(MS_SLOTS + SEC_SLOTS);
	localparam logic [SLOT_W-1:0] HOUR_BASE = SLOT_W'(MS_SLOTS + 2 * SEC_SLOTS);
	localparam logic [HEAD_W-1:0] NONE      = HEAD_W'(ENTRIES);

	// Time and delay words are packed as {hours, minutes, seconds, millis}.
	localparam int DLY_W  = 27;
	localparam int INFO_W = 8 + 1 + DLY_W;

	typedef enum logic [1:0] {
		F_TICK   = 2'd0,
		F_ADD    = 2'd1,
		F_CANCEL = 2'd2,
		F_UNUSED = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		K_NONE     = 3'd0,
		K_EXPIRED  = 3'd1,
		K_ACCEPTED = 3'd2,
		K_FULL     = 3'd3,
		K_ZERO     = 3'd4
	} kind_t;

endpackage

### rtl/hierarchical_timer_wheel.sv
// Four-level timing wheel (millisecond, second, minute, hour) with a small sequencer.
//
// Items are taken when start is high and busy is low; each item then runs to completion
// under a sequencer while busy stays high. Results appear on kind, expired_handle,
// was_periodic and last for exactly one cycle, marked by strobe, and the receiver cannot
// hold them off; last marks the final result of an item. A cancel or an unused function
// goes straight to the finishing step. An add scans the pool for the first free entry, then
// arms it and places it in a slot. A tick walks the current millisecond slot, firing
// one-shot entries, freeing cancelled periodic entries and re-arming other periodic entries;
// when a second, minute or hour boundary is crossed, each level due is cascaded and each of
// its entries is moved down a level. The walk over the slot lists, one entry at a time
// through the entry and slot memories, sets how long an item takes. After reset the block
// clears the slot head memory, with busy high, before it takes its first item.
module hierarchical_timer_wheel (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] func,
	input  logic [7:0] handle,
	input  logic       periodic,
	input  logic [4:0] delay_hours,
	input  logic [5:0] delay_minutes,
	input  logic [5:0] delay_seconds,
	input  logic [9:0] delay_millis,
	output logic       busy,
	output logic       strobe,
	output logic [2:0] kind,
	output logic [7:0] expired_handle,
	output logic       was_periodic,
	output logic       last
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_NORM, S_SCAN, S_ARM, S_PLACE, S_PUSH_RD, S_PUSH_WR,
		S_DRAIN_RD, S_DRAIN_DATA, S_WALK_RD, S_WALK_DATA, S_WALK_NEXT,
		S_ADVANCE, S_CAS_SEL, S_FINISH
	} state_t;

	localparam int SW = htw_pkg::SLOT_W;
	localparam int EW = htw_pkg::EW;
	localparam int HW = htw_pkg::HEAD_W;

	state_t state_q;

	// Current time of day, one register per digit.
	logic [9:0] now_ms_q;
	logic [5:0] now_s_q;
	logic [5:0] now_m_q;
	logic [4:0] now_h_q;

	logic [htw_pkg::ENTRIES-1:0] in_use_q;
	logic [htw_pkg::HANDLES-1:0] cancel_q;

	// Latched add item.
	logic [7:0] handle_q;
	logic       periodic_q;
	logic [4:0] dh_q;
	logic [5:0] dm_q;
	logic [5:0] ds_q;
	logic [9:0] dms_q;
	logic [htw_pkg::DLY_W-1:0] dnorm_q;

	// Sequencer working registers.
	logic [SW-1:0] clr_q;
	logic [EW-1:0] scan_q;
	logic [EW-1:0] cur_q;
	logic [EW-1:0] nxt_q;
	logic          end_q;
	logic [EW-1:0] drain_tail_q;
	logic [SW-1:0] drain_slot_q;
	logic [SW-1:0] push_slot_q;
	logic [htw_pkg::DLY_W-1:0] arm_d_q;
	logic [htw_pkg::DLY_W-1:0] tgt_q;
	logic          ctx_add_q;
	logic          fire_q;
	logic [1:0]    lvl_q;
	logic          cas_h_q, cas_m_q, cas_s_q;

	// Result held back until it is known whether another follows.
	logic       pend_v_q;
	logic [2:0] pend_kind_q;
	logic [7:0] pend_h_q;
	logic       pend_p_q;

	// Memories: slot heads and tails, and the entry pool.
	logic [HW-1:0] head_mem [htw_pkg::NSLOTS];
	logic [EW-1:0] tail_mem [htw_pkg::NSLOTS];
	logic [htw_pkg::INFO_W-1:0] info_mem [htw_pkg::ENTRIES];
	logic [htw_pkg::DLY_W-1:0]  target_mem [htw_pkg::ENTRIES];
	logic [EW-1:0] next_mem [htw_pkg::ENTRIES];

	logic [HW-1:0] head_rd_q;
	logic [EW-1:0] tail_rd_q;
	logic [htw_pkg::INFO_W-1:0] info_rd_q;
	logic [htw_pkg::DLY_W-1:0]  target_rd_q;
	logic [EW-1:0] next_rd_q;

	logic [SW-1:0] slot_raddr;
	logic          head_we;
	logic [SW-1:0] head_waddr;
	logic [HW-1:0] head_wdata;
	logic          push_empty;

	// Target time of the entry being armed, built further down.
	logic [htw_pkg::DLY_W-1:0] tgt_next;

	assign busy       = (state_q != S_IDLE);
	assign slot_raddr = (state_q == S_PUSH_RD) ? push_slot_q : drain_slot_q;
	assign push_empty = (head_rd_q == htw_pkg::NONE);

	always_comb begin
		head_we    = 1'b0;
		head_waddr = drain_slot_q;
		head_wdata = htw_pkg::NONE;
		unique case (state_q)
			S_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
			end
			S_DRAIN_DATA: begin
				head_we    = 1'b1;
			end
			S_PUSH_WR: begin
				head_we    = push_empty;
				head_waddr = push_slot_q;
				head_wdata = {1'b0, cur_q};
			end
			default: begin
				head_we    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		if (state_q == S_PUSH_WR) begin
			tail_mem[push_slot_q] <= cur_q;
		end
		head_rd_q <= head_mem[slot_raddr];
		tail_rd_q <= tail_mem[slot_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && !in_use_q[scan_q]) begin
			info_mem[scan_q] <= {handle_q, periodic_q, dnorm_q};
		end
		if (state_q == S_ARM) begin
			target_mem[cur_q] <= tgt_next;
		end
		if (state_q == S_PUSH_WR && !push_empty) begin
			next_mem[tail_rd_q] <= cur_q;
		end
		info_rd_q   <= info_mem[cur_q];
		target_rd_q <= target_mem[cur_q];
		next_rd_q   <= next_mem[cur_q];
	end

	// Delay folded into one day: each digit carries into the next by one compare.
	logic       nc0, nc1, nc2;
	logic [9:0] n_ms;
	logic [6:0] n_s0, n_m0;
	logic [5:0] n_s, n_m, n_h0;
	logic [4:0] n_h;
	logic [htw_pkg::DLY_W-1:0] dnorm;

	always_comb begin
		nc0   = (dms_q >= 10'(htw_pkg::MS_SLOTS));
		n_ms  = nc0 ? dms_q - 10'(htw_pkg::MS_SLOTS) : dms_q;
		n_s0  = {1'b0, ds_q} + 7'(nc0);
		nc1   = (n_s0 >= 7'(htw_pkg::SEC_SLOTS));
		n_s   = nc1 ? 6'(n_s0 - 7'(htw_pkg::SEC_SLOTS)) : n_s0[5:0];
		n_m0  = {1'b0, dm_q} + 7'(nc1);
		nc2   = (n_m0 >= 7'(htw_pkg::SEC_SLOTS));
		n_m   = nc2 ? 6'(n_m0 - 7'(htw_pkg::SEC_SLOTS)) : n_m0[5:0];
		n_h0  = {1'b0, dh_q} + 6'(nc2);
		n_h   = (n_h0 >= 6'(htw_pkg::HOUR_SLOTS)) ?
			5'(n_h0 - 6'(htw_pkg::HOUR_SLOTS)) : n_h0[4:0];
		dnorm = {n_h, n_m, n_s, n_ms};
	end

	// Target time: current time plus the armed delay, wrapped at one day.
	logic        ac0, ac1, ac2;
	logic [10:0] a_ms;
	logic [6:0]  a_s, a_m;
	logic [5:0]  a_h;
	logic [9:0]  t_ms;
	logic [5:0]  t_s, t_m;
	logic [4:0]  t_h;

	always_comb begin
		a_ms = {1'b0, now_ms_q} + {1'b0, arm_d_q[9:0]};
		ac0  = (a_ms >= 11'(htw_pkg::MS_SLOTS));
		t_ms = ac0 ? 10'(a_ms - 11'(htw_pkg::MS_SLOTS)) : a_ms[9:0];
		a_s  = {1'b0, now_s_q} + {1'b0, arm_d_q[15:10]} + 7'(ac0);
		ac1  = (a_s >= 7'(htw_pkg::SEC_SLOTS));
		t_s  = ac1 ? 6'(a_s - 7'(htw_pkg::SEC_SLOTS)) : a_s[5:0];
		a_m  = {1'b0, now_m_q} + {1'b0, arm_d_q[21:16]} + 7'(ac1);
		ac2  = (a_m >= 7'(htw_pkg::SEC_SLOTS));
		t_m  = ac2 ? 6'(a_m - 7'(htw_pkg::SEC_SLOTS)) : a_m[5:0];
		a_h  = {1'b0, now_h_q} + {1'b0, arm_d_q[26:22]} + 6'(ac2);
		t_h  = (a_h >= 6'(htw_pkg::HOUR_SLOTS)) ?
			5'(a_h - 6'(htw_pkg::HOUR_SLOTS)) : a_h[4:0];
		tgt_next = {t_h, t_m, t_s, t_ms};
	end

	// Slot choice for a newly armed entry: the highest level whose digit differs.
	// A target earlier than now within the current hour wraps round the day, so it
	// is parked in the current hour slot.
	logic [SW-1:0] place_slot;

	always_comb begin
		priority if (tgt_q[26:22] != now_h_q ||
			tgt_q[21:0] < {now_m_q, now_s_q, now_ms_q}) begin
			place_slot = htw_pkg::HOUR_BASE + SW'(tgt_q[26:22]);
		end else if (tgt_q[21:16] != now_m_q) begin
			place_slot = htw_pkg::MIN_BASE + SW'(tgt_q[21:16]);
		end else if (tgt_q[15:10] != now_s_q) begin
			place_slot = htw_pkg::SEC_BASE + SW'(tgt_q[15:10]);
		end else begin
			place_slot = SW'(tgt_q[9:0]);
		end
	end

	// Slot one level down for an entry being cascaded.
	logic [SW-1:0] cas_slot;

	always_comb begin
		unique case (lvl_q)
			2'd2:    cas_slot = htw_pkg::MIN_BASE + SW'(target_rd_q[21:16]);
			2'd1:    cas_slot = htw_pkg::SEC_BASE + SW'(target_rd_q[15:10]);
			default: cas_slot = SW'(target_rd_q[9:0]);
		endcase
	end

	// Fields of the entry read for the walk.
	logic [7:0] ent_handle;
	logic       ent_periodic;
	logic [htw_pkg::DLY_W-1:0] ent_delay;
	logic       ent_cancelled;

	assign ent_handle    = info_rd_q[htw_pkg::INFO_W-1 -: 8];
	assign ent_periodic  = info_rd_q[htw_pkg::DLY_W];
	assign ent_delay     = info_rd_q[htw_pkg::DLY_W-1:0];
	assign ent_cancelled = cancel_q[ent_handle];

	// A new result from the current step of the sequencer.
	logic       emit_v;
	logic [2:0] emit_kind;
	logic [7:0] emit_h;
	logic       emit_p;

	always_comb begin
		emit_v    = 1'b0;
		emit_kind = htw_pkg::K_NONE;
		emit_h    = 8'd0;
		emit_p    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (func == htw_pkg::F_CANCEL) begin
						emit_v    = 1'b1;
						emit_kind = htw_pkg::K_ACCEPTED;
						emit_h    = handle;
					end else if (func == htw_pkg::F_UNUSED) begin
						emit_v    = 1'b1;
					end
				end
			end
			S_NORM: begin
				if (dnorm == '0) begin
					emit_v    = 1'b1;
					emit_kind = htw_pkg::K_ZERO;
					emit_h    = handle_q;
				end
			end
			S_SCAN: begin
				if (in_use_q[scan_q] && scan_q == EW'(htw_pkg::ENTRIES - 1)) begin
					emit_v    = 1'b1;
					emit_kind = htw_pkg::K_FULL;
					emit_h    = handle_q;
				end
			end
			S_PUSH_WR: begin
				if (ctx_add_q) begin
					emit_v    = 1'b1;
					emit_kind = htw_pkg::K_ACCEPTED;
					emit_h    = handle_q;
				end
			end
			S_WALK_DATA: begin
				if (fire_q && !(ent_periodic && ent_cancelled)) begin
					emit_v    = 1'b1;
					emit_kind = htw_pkg::K_EXPIRED;
					emit_h    = ent_handle;
					emit_p    = ent_periodic;
				end
			end
			default: begin
				emit_v    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			now_ms_q       <= '0;
			now_s_q        <= '0;
			now_m_q        <= '0;
			now_h_q        <= '0;
			in_use_q       <= '0;
			cancel_q       <= '0;
			pend_v_q       <= 1'b0;
			cas_h_q        <= 1'b0;
			cas_m_q        <= 1'b0;
			cas_s_q        <= 1'b0;
			strobe         <= 1'b0;
			kind           <= '0;
			expired_handle <= '0;
			was_periodic   <= 1'b0;
			last           <= 1'b0;
		end else begin
			strobe <= 1'b0;

			// A new result releases the one held back, which is then known not to be last.
			if (emit_v) begin
				if (pend_v_q) begin
					strobe         <= 1'b1;
					kind           <= pend_kind_q;
					expired_handle <= pend_h_q;
					was_periodic   <= pend_p_q;
					last           <= 1'b0;
				end
				pend_v_q    <= 1'b1;
				pend_kind_q <= emit_kind;
				pend_h_q    <= emit_h;
				pend_p_q    <= emit_p;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(htw_pkg::NSLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						handle_q   <= handle;
						periodic_q <= periodic;
						dh_q       <= delay_hours;
						dm_q       <= delay_minutes;
						ds_q       <= delay_seconds;
						dms_q      <= delay_millis;
						unique case (func)
							htw_pkg::F_TICK: begin
								drain_slot_q <= SW'(now_ms_q);
								fire_q       <= 1'b1;
								state_q      <= S_DRAIN_RD;
							end
							htw_pkg::F_ADD: begin
								state_q <= S_NORM;
							end
							htw_pkg::F_CANCEL: begin
								cancel_q[handle] <= 1'b1;
								state_q          <= S_FINISH;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_NORM: begin
					dnorm_q <= dnorm;
					scan_q  <= '0;
					state_q <= (dnorm == '0) ? S_FINISH : S_SCAN;
				end
				S_SCAN: begin
					if (!in_use_q[scan_q]) begin
						in_use_q[scan_q] <= 1'b1;
						cur_q            <= scan_q;
						arm_d_q          <= dnorm_q;
						ctx_add_q        <= 1'b1;
						state_q          <= S_ARM;
					end else if (scan_q == EW'(htw_pkg::ENTRIES - 1)) begin
						state_q <= S_FINISH;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_ARM: begin
					tgt_q   <= tgt_next;
					state_q <= S_PLACE;
				end
				S_PLACE: begin
					push_slot_q <= place_slot;
					state_q     <= S_PUSH_RD;
				end
				S_PUSH_RD: begin
					state_q <= S_PUSH_WR;
				end
				S_PUSH_WR: begin
					state_q <= ctx_add_q ? S_FINISH : S_WALK_NEXT;
				end
				S_DRAIN_RD: begin
					state_q <= S_DRAIN_DATA;
				end
				S_DRAIN_DATA: begin
					if (head_rd_q == htw_pkg::NONE) begin
						state_q <= fire_q ? S_ADVANCE : S_CAS_SEL;
					end else begin
						cur_q        <= head_rd_q[EW-1:0];
						drain_tail_q <= tail_rd_q;
						state_q      <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_DATA;
				end
				S_WALK_DATA: begin
					nxt_q     <= next_rd_q;
					end_q     <= (cur_q == drain_tail_q);
					ctx_add_q <= 1'b0;
					if (fire_q) begin
						if (ent_periodic && ent_cancelled) begin
							cancel_q[ent_handle] <= 1'b0;
							in_use_q[cur_q]      <= 1'b0;
							state_q              <= S_WALK_NEXT;
						end else if (ent_periodic) begin
							arm_d_q <= ent_delay;
							state_q <= S_ARM;
						end else begin
							in_use_q[cur_q] <= 1'b0;
							state_q         <= S_WALK_NEXT;
						end
					end else begin
						push_slot_q <= cas_slot;
						state_q     <= S_PUSH_RD;
					end
				end
				S_WALK_NEXT: begin
					if (end_q) begin
						state_q <= fire_q ? S_ADVANCE : S_CAS_SEL;
					end else begin
						cur_q   <= nxt_q;
						state_q <= S_WALK_RD;
					end
				end
				S_ADVANCE: begin
					fire_q  <= 1'b0;
					cas_h_q <= 1'b0;
					cas_m_q <= 1'b0;
					cas_s_q <= 1'b0;
					if (now_ms_q == 10'(htw_pkg::MS_SLOTS - 1)) begin
						now_ms_q <= '0;
						cas_s_q  <= 1'b1;
						if (now_s_q == 6'(htw_pkg::SEC_SLOTS - 1)) begin
							now_s_q <= '0;
							cas_m_q <= 1'b1;
							if (now_m_q == 6'(htw_pkg::SEC_SLOTS - 1)) begin
								now_m_q <= '0;
								cas_h_q <= 1'b1;
								if (now_h_q == 5'(htw_pkg::HOUR_SLOTS - 1)) begin
									now_h_q <= '0;
								end else begin
									now_h_q <= now_h_q + 1'b1;
								end
							end else begin
								now_m_q <= now_m_q + 1'b1;
							end
						end else begin
							now_s_q <= now_s_q + 1'b1;
						end
					end else begin
						now_ms_q <= now_ms_q + 1'b1;
					end
					state_q <= S_CAS_SEL;
				end
				S_CAS_SEL: begin
					// Hour first, then minute, then second, as the levels feed downward.
					priority if (cas_h_q) begin
						cas_h_q      <= 1'b0;
						lvl_q        <= 2'd2;
						drain_slot_q <= htw_pkg::HOUR_BASE + SW'(now_h_q);
						state_q      <= S_DRAIN_RD;
					end else if (cas_m_q) begin
						cas_m_q      <= 1'b0;
						lvl_q        <= 2'd1;
						drain_slot_q <= htw_pkg::MIN_BASE + SW'(now_m_q);
						state_q      <= S_DRAIN_RD;
					end else if (cas_s_q) begin
						cas_s_q      <= 1'b0;
						lvl_q        <= 2'd0;
						drain_slot_q <= htw_pkg::SEC_BASE + SW'(now_s_q);
						state_q      <= S_DRAIN_RD;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					strobe   <= 1'b1;
					last     <= 1'b1;
					pend_v_q <= 1'b0;
					if (pend_v_q) begin
						kind           <= pend_kind_q;
						expired_handle <= pend_h_q;
						was_periodic   <= pend_p_q;
					end else begin
						kind           <= htw_pkg::K_NONE;
						expired_handle <= '0;
						was_periodic   <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/htw_checker.sv
// Port-level checker for the hierarchical timer wheel, bound to the top level.
module htw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [2:0] kind,
	input logic [7:0] expired_handle,
	input logic       was_periodic,
	input logic       last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result while the block is idle");

	a_more_expired: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> kind == htw_pkg::K_EXPIRED)
		else $error("only expiries may be followed by further results");

	a_periodic_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && was_periodic |-> kind == htw_pkg::K_EXPIRED)
		else $error("periodic flag on a result that is not an expiry");

	a_none_fields: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == htw_pkg::K_NONE |-> expired_handle == 8'd0 && last)
		else $error("empty tick result carries a handle or is not final");

endmodule

bind hierarchical_timer_wheel htw_checker u_htw_checker (.*);
